>>> sv/brle_pkg.sv
// Shared types and constants of the BMP RLE palette decoder.
`timescale 1ns / 1ps

package brle_pkg;

   localparam int MAX_WIDTH_DEF     = 4096;
   localparam int MAX_HEIGHT_DEF    = 4096;
   localparam int PALETTE_DEPTH_DEF = 256;

   localparam int COLOR_W = 24;
   localparam int LEN_W   = 25;
   localparam int POS_W   = 13;
   localparam int BYTE_W  = 8;
   localparam int CSR_W   = 13;
   localparam int CSR_IW  = 2;

   typedef enum logic [1:0] {
      MODE_PALETTE = 2'd0,
      MODE_BYTE    = 2'd1,
      MODE_START   = 2'd2
   } mode_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_COMPRESSION = 2'd0,
      CSR_WIDTH       = 2'd1,
      CSR_HEIGHT      = 2'd2
   } csr_index_type;

   typedef enum logic [BYTE_W-1:0] {
      ESC_EOL   = 8'd0,
      ESC_EOB   = 8'd1,
      ESC_DELTA = 8'd2
   } escape_type;

   typedef enum logic [2:0] {
      PH_COUNT  = 3'd0,
      PH_VALUE  = 3'd1,
      PH_ABS    = 3'd2,
      PH_PAD    = 3'd3,
      PH_DELTA1 = 3'd4,
      PH_DELTA2 = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   typedef struct packed {
      logic             fill;
      logic             blk_even;
      logic             blk_odd;
      logic             two;
      logic [LEN_W-1:0] len0;
      logic [LEN_W-1:0] len1;
   } run_type;

endpackage

>>> sv/bmp_rle_palette_decoder.sv
// Top level of the BMP RLE8/RLE4 decoder with palette expansion.
`timescale 1ns / 1ps

// Usage:
// Requests on req_* carry a palette write (mode 0), one byte of an RLE8 or
// RLE4 stream (mode 1) or a start of a new image (mode 2). Each stream byte
// may give zero, one or two runs on rsp_*: an even and an odd color, a run
// length, a row-end flag and a last flag on the final fill of the bitmap.
// The csr_* port sets compression mode, image width and image height; write
// it only while the block is idle.
// Timing: a request that produces runs is registered together with the
// palette read data, then its runs move to the response register. One
// request is taken per cycle while req_stall is low; an end-of-bitmap
// byte holds the run stage until both of its runs have entered the single
// response register.
// Requests that produce no run never wait on the response side unless the
// run stage is full and blocked.
// Reset clears the parser, counters, valid flags and configuration
// (RLE8, 1 x 1 image); the palette holds unknown values until written.
// While rsp_stall is high the response holds, one further run waits in
// the run stage, and then req_stall rises.
module bmp_rle_palette_decoder #(
   parameter int MAX_WIDTH     = brle_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = brle_pkg::MAX_HEIGHT_DEF,
   parameter int PALETTE_DEPTH = brle_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [brle_pkg::BYTE_W-1:0]   req_stream_byte,
   input  logic [brle_pkg::BYTE_W-1:0]   req_palette_index,
   input  logic [brle_pkg::COLOR_W-1:0]  req_palette_color,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brle_pkg::COLOR_W-1:0]  rsp_even_color,
   output logic [brle_pkg::COLOR_W-1:0]  rsp_odd_color,
   output logic [brle_pkg::LEN_W-1:0]    rsp_run_length,
   output logic                          rsp_row_end,
   output logic                          rsp_last,
   input  logic                          csr_write,
   input  logic [brle_pkg::CSR_IW-1:0]   csr_index,
   input  logic [brle_pkg::CSR_W-1:0]    csr_data
);

   localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int POS_W  = brle_pkg::POS_W;
   localparam int LEN_W  = brle_pkg::LEN_W;
   localparam int BW     = brle_pkg::BYTE_W;
   localparam int CW     = brle_pkg::COLOR_W;

   logic [CW-1:0] palette_mem [0:PALETTE_DEPTH-1];

   logic             rle4_ff;
   logic [POS_W-1:0] width_ff;
   logic [POS_W-1:0] height_ff;

   brle_pkg::phase_type phase_ff, phase_in;
   logic [BW-1:0]       pend_ff, pend_in;
   logic [BW-1:0]       left_ff, left_in;
   logic                pad_ff, pad_in;
   logic [POS_W-1:0]    col_ff, col_in;
   logic [POS_W-1:0]    row_ff, row_in;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_sub_ff, s1_sub_in;
   brle_pkg::run_type   s1_ff;
   brle_pkg::run_type   run_in;
   logic [CW-1:0]       rd_even_ff;
   logic [CW-1:0]       rd_odd_ff;

   logic                out_valid_ff, out_valid_in;
   logic [CW-1:0]       out_even_ff, out_even_in;
   logic [CW-1:0]       out_odd_ff, out_odd_in;
   logic [LEN_W-1:0]    out_len_ff, out_len_in;
   logic                out_rend_ff, out_rend_in;
   logic                out_last_ff, out_last_in;

   logic                accept;
   logic                out_free;
   logic                s1_done;
   logic                s1_load;
   logic                res_any;
   logic [BW-1:0]       b;
   logic [BW-1:0]       addr_even;
   logic [BW-1:0]       addr_odd;
   logic [POS_W-1:0]    w_eff;
   logic [POS_W-1:0]    h_eff;
   logic [POS_W-1:0]    row_fill;
   logic [POS_W-1:0]    col_fill;
   logic [2*POS_W-1:0]  rows_prod;
   logic [BW-1:0]       adv;
   logic [POS_W:0]      col_sum;
   logic [BW:0]         b_plus;
   logic [1:0]          abs_n;
   logic                pal_wr;

   assign b        = req_stream_byte;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_done  = s1_valid_ff && out_free && (s1_sub_ff || !s1_ff.two);
   assign req_stall = s1_valid_ff && !s1_done;
   assign accept   = req_valid && !req_stall;
   assign s1_load  = accept && res_any;

   assign pal_wr = accept && (brle_pkg::mode_type'(req_mode) == brle_pkg::MODE_PALETTE)
                   && ({1'b0, req_palette_index} < (BW+1)'(PALETTE_DEPTH));

   // clamp image size
   always_comb begin
      if (width_ff == '0) begin
         w_eff = POS_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = POS_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = POS_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = POS_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign col_fill = (col_ff < w_eff) ? (w_eff - col_ff) : '0;
   assign row_fill = (({1'b0, row_ff} + (POS_W+1)'(1)) < {1'b0, h_eff}) ?
                     (h_eff - row_ff - POS_W'(1)) : '0;
   assign rows_prod = (2*POS_W)'(row_fill) * (2*POS_W)'(w_eff);
   assign col_sum  = {1'b0, col_ff} + (POS_W+1)'(adv);
   assign b_plus   = {1'b0, b} + (BW+1)'(1);
   assign abs_n    = (left_ff >= BW'(2)) ? 2'd2 : left_ff[1:0];

   assign addr_even = rle4_ff ? {4'b0, b[7:4]} : b;
   assign addr_odd  = rle4_ff ? {4'b0, b[3:0]} : b;

   // parser: next state and run descriptor
   always_comb begin
      phase_in = phase_ff;
      pend_in  = pend_ff;
      left_in  = left_ff;
      pad_in   = pad_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      res_any  = 1'b0;
      adv      = '0;
      run_in.fill     = 1'b0;
      run_in.blk_even = {1'b0, addr_even} >= (BW+1)'(PALETTE_DEPTH);
      run_in.blk_odd  = {1'b0, addr_odd} >= (BW+1)'(PALETTE_DEPTH);
      run_in.two      = 1'b0;
      run_in.len0     = '0;
      run_in.len1     = (rows_prod > (2*POS_W)'({LEN_W{1'b1}})) ?
                        {LEN_W{1'b1}} : rows_prod[LEN_W-1:0];
      unique case (brle_pkg::mode_type'(req_mode))
         brle_pkg::MODE_START: begin
            phase_in = brle_pkg::PH_COUNT;
            pend_in  = '0;
            left_in  = '0;
            pad_in   = 1'b0;
            col_in   = '0;
            row_in   = '0;
         end
         brle_pkg::MODE_BYTE: begin
            unique case (phase_ff)
               brle_pkg::PH_COUNT: begin
                  pend_in  = b;
                  phase_in = brle_pkg::PH_VALUE;
               end
               brle_pkg::PH_VALUE: begin
                  if (pend_ff != '0) begin
                     res_any     = 1'b1;
                     run_in.len0 = LEN_W'(pend_ff);
                     adv         = pend_ff;
                     col_in      = col_sum[POS_W] ? {POS_W{1'b1}} : col_sum[POS_W-1:0];
                     phase_in    = brle_pkg::PH_COUNT;
                  end else begin
                     case (b)
                        brle_pkg::ESC_EOL: begin
                           res_any     = 1'b1;
                           run_in.fill = 1'b1;
                           run_in.len0 = LEN_W'(col_fill);
                           col_in      = '0;
                           row_in      = (row_ff == {POS_W{1'b1}}) ? row_ff : row_ff + POS_W'(1);
                           phase_in    = brle_pkg::PH_COUNT;
                        end
                        brle_pkg::ESC_EOB: begin
                           res_any     = 1'b1;
                           run_in.fill = 1'b1;
                           run_in.two  = 1'b1;
                           run_in.len0 = LEN_W'(col_fill);
                           phase_in    = brle_pkg::PH_DONE;
                        end
                        brle_pkg::ESC_DELTA: begin
                           phase_in = brle_pkg::PH_DELTA1;
                        end
                        default: begin
                           left_in  = b;
                           pad_in   = rle4_ff ? b_plus[1] : b[0];
                           phase_in = brle_pkg::PH_ABS;
                        end
                     endcase
                  end
               end
               brle_pkg::PH_ABS: begin
                  res_any     = 1'b1;
                  adv         = rle4_ff ? BW'(abs_n) : BW'(1);
                  run_in.len0 = LEN_W'(adv);
                  col_in      = col_sum[POS_W] ? {POS_W{1'b1}} : col_sum[POS_W-1:0];
                  left_in     = left_ff - adv;
                  if (left_in == '0) begin
                     phase_in = pad_ff ? brle_pkg::PH_PAD : brle_pkg::PH_COUNT;
                  end
               end
               brle_pkg::PH_PAD: begin
                  pad_in   = 1'b0;
                  phase_in = brle_pkg::PH_COUNT;
               end
               brle_pkg::PH_DELTA1: begin
                  phase_in = brle_pkg::PH_DELTA2;
               end
               brle_pkg::PH_DELTA2: begin
                  phase_in = brle_pkg::PH_COUNT;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // run stage and response register next values
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_sub_in    = s1_sub_ff;
      out_valid_in = out_valid_ff;
      out_even_in  = out_even_ff;
      out_odd_in   = out_odd_ff;
      out_len_in   = out_len_ff;
      out_rend_in  = out_rend_ff;
      out_last_in  = out_last_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
         if (s1_sub_ff) begin
            out_even_in = '0;
            out_odd_in  = '0;
            out_len_in  = s1_ff.len1;
            out_rend_in = 1'b1;
            out_last_in = 1'b1;
         end else begin
            out_even_in = (s1_ff.fill || s1_ff.blk_even) ? '0 : rd_even_ff;
            out_odd_in  = (s1_ff.fill || s1_ff.blk_odd) ? '0 : rd_odd_ff;
            out_len_in  = s1_ff.len0;
            out_rend_in = s1_ff.fill;
            out_last_in = 1'b0;
         end
      end
      if (s1_load) begin
         s1_valid_in = 1'b1;
         s1_sub_in   = 1'b0;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
         s1_sub_in   = 1'b0;
      end else if (s1_valid_ff && out_free) begin
         s1_sub_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rle4_ff   <= 1'b0;
         width_ff  <= POS_W'(1);
         height_ff <= POS_W'(1);
      end else if (csr_write) begin
         case (brle_pkg::csr_index_type'(csr_index))
            brle_pkg::CSR_COMPRESSION: rle4_ff   <= csr_data[0];
            brle_pkg::CSR_WIDTH:       width_ff  <= csr_data[POS_W-1:0];
            brle_pkg::CSR_HEIGHT:      height_ff <= csr_data[POS_W-1:0];
            default:                   rle4_ff   <= rle4_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= brle_pkg::PH_COUNT;
         pend_ff  <= '0;
         left_ff  <= '0;
         pad_ff   <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         left_ff  <= left_in;
         pad_ff   <= pad_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_sub_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_sub_ff    <= s1_sub_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= run_in;
      end
      out_even_ff <= out_even_in;
      out_odd_ff  <= out_odd_in;
      out_len_ff  <= out_len_in;
      out_rend_ff <= out_rend_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (pal_wr) begin
         palette_mem[req_palette_index[PAL_AW-1:0]] <= req_palette_color;
      end
      if (s1_load) begin
         rd_even_ff <= palette_mem[addr_even[PAL_AW-1:0]];
         rd_odd_ff  <= palette_mem[addr_odd[PAL_AW-1:0]];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_even_color = out_even_ff;
   assign rsp_odd_color  = out_odd_ff;
   assign rsp_run_length = out_len_ff;
   assign rsp_row_end    = out_rend_ff;
   assign rsp_last       = out_last_ff;

   a_sub_two : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_sub_ff |-> s1_ff.two)
      else $error("second run selected on a single-run request");

   a_last_black : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_row_end && rsp_even_color == '0 && rsp_odd_color == '0)
      else $error("final run is not a black row-end fill");

   a_stall_src : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && (rsp_stall || s1_ff.two))
      else $error("request stalled without a blocked run");

   a_eob_done : assert property (@(posedge clock) disable iff (reset)
      s1_load && run_in.two |=> phase_ff == brle_pkg::PH_DONE)
      else $error("end of bitmap did not close the parser");

   a_done_quiet : assert property (@(posedge clock) disable iff (reset)
      phase_ff == brle_pkg::PH_DONE && accept |-> !s1_load)
      else $error("run produced after end of bitmap");

endmodule

>>> sim/tb.sv
// Self-checking bench for the BMP RLE palette decoder: random RLE8/RLE4 streams scored per run.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE = 8;
   localparam int PHASE_REQUESTS = 220;
   localparam int POS_LIMIT = 8191;
   localparam logic [brle_pkg::BYTE_W-1:0] ESCAPE_COUNT = 8'h00;

   typedef struct {
      logic [brle_pkg::COLOR_W-1:0] even_color;
      logic [brle_pkg::COLOR_W-1:0] odd_color;
      logic [brle_pkg::LEN_W-1:0]   run_length;
      logic                         row_end;
      logic                         last;
   } run_rec_type;

   class rle_scoreboard_type;
      logic [brle_pkg::COLOR_W-1:0] palette [256];
      bit written [256];
      int used_all [$];
      int used_low [$];
      brle_pkg::phase_type parse_state;
      logic [7:0] pend_count;
      logic [7:0] abs_left;
      bit pad_due;
      int column;
      int row;
      bit rle4;
      int width_reg;
      int height_reg;
      run_rec_type pending_runs [$];
      int errors;
      int runs_checked;
      int bitmaps_done;
      int requests;

      function new();
         foreach (palette[i]) begin
            palette[i] = '0;
            written[i] = 1'b0;
         end
         restart_image();
         rle4 = 1'b0;
         width_reg = 1;
         height_reg = 1;
         errors = 0;
         runs_checked = 0;
         bitmaps_done = 0;
         requests = 0;
      endfunction

      function void restart_image();
         parse_state = brle_pkg::PH_COUNT;
         pend_count = '0;
         abs_left = '0;
         pad_due = 1'b0;
         column = 0;
         row = 0;
      endfunction

      function void set_reg(brle_pkg::csr_index_type idx, int val);
         case (idx)
            brle_pkg::CSR_COMPRESSION: rle4 = val[0];
            brle_pkg::CSR_WIDTH: width_reg = val & 13'h1FFF;
            brle_pkg::CSR_HEIGHT: height_reg = val & 13'h1FFF;
            default: ;
         endcase
      endfunction

      function void add_run(logic [brle_pkg::COLOR_W-1:0] ev,
                            logic [brle_pkg::COLOR_W-1:0] od, int len,
                            bit rend, bit lst);
         run_rec_type r;
         r.even_color = ev;
         r.odd_color = od;
         r.run_length = brle_pkg::LEN_W'(len);
         r.row_end = rend;
         r.last = lst;
         pending_runs.push_back(r);
      endfunction

      function void advance_column(int n);
         column = (column + n > POS_LIMIT) ? POS_LIMIT : column + n;
      endfunction

      // swap any unwritten palette index that this byte would read
      function logic [7:0] usable_byte(logic [7:0] b);
         logic [3:0] hi;
         logic [3:0] lo;
         if (!((parse_state == brle_pkg::PH_VALUE && pend_count != 0) ||
               parse_state == brle_pkg::PH_ABS))
            return b;
         if (rle4) begin
            hi = b[7:4];
            lo = b[3:0];
            if (!written[hi]) hi = 4'(used_low[$urandom_range(0, used_low.size() - 1)]);
            if (!written[lo]) lo = 4'(used_low[$urandom_range(0, used_low.size() - 1)]);
            return {hi, lo};
         end
         if (!written[b]) return 8'(used_all[$urandom_range(0, used_all.size() - 1)]);
         return b;
      endfunction

      function void decode_request(logic [1:0] m, logic [7:0] b, logic [7:0] idx,
                                   logic [brle_pkg::COLOR_W-1:0] rgb);
         int w;
         int h;
         int n;
         requests++;
         w = (width_reg < 1) ? 1 :
             (width_reg > brle_pkg::MAX_WIDTH_DEF ? brle_pkg::MAX_WIDTH_DEF : width_reg);
         h = (height_reg < 1) ? 1 :
             (height_reg > brle_pkg::MAX_HEIGHT_DEF ? brle_pkg::MAX_HEIGHT_DEF : height_reg);
         if (m == brle_pkg::MODE_PALETTE) begin
            palette[idx] = rgb;
            if (!written[idx]) begin
               written[idx] = 1'b1;
               used_all.push_back(int'(idx));
               if (idx < 16) used_low.push_back(int'(idx));
            end
         end else if (m == brle_pkg::MODE_START) begin
            restart_image();
         end else if (m == brle_pkg::MODE_BYTE) begin
            case (parse_state)
               brle_pkg::PH_COUNT: begin
                  pend_count = b;
                  parse_state = brle_pkg::PH_VALUE;
               end
               brle_pkg::PH_VALUE: begin
                  if (pend_count != 0) begin
                     if (rle4) add_run(palette[b[7:4]], palette[b[3:0]], int'(pend_count),
                                       1'b0, 1'b0);
                     else add_run(palette[b], palette[b], int'(pend_count), 1'b0, 1'b0);
                     advance_column(int'(pend_count));
                     parse_state = brle_pkg::PH_COUNT;
                  end else if (b == brle_pkg::ESC_EOL) begin
                     add_run('0, '0, (column < w) ? w - column : 0, 1'b1, 1'b0);
                     column = 0;
                     if (row < POS_LIMIT) row++;
                     parse_state = brle_pkg::PH_COUNT;
                  end else if (b == brle_pkg::ESC_EOB) begin
                     add_run('0, '0, (column < w) ? w - column : 0, 1'b1, 1'b0);
                     add_run('0, '0, ((row + 1 < h) ? h - row - 1 : 0) * w, 1'b1, 1'b1);
                     parse_state = brle_pkg::PH_DONE;
                  end else if (b == brle_pkg::ESC_DELTA) begin
                     parse_state = brle_pkg::PH_DELTA1;
                  end else begin
                     abs_left = b;
                     pad_due = rle4 ? 1'((int'(b) + 1) >> 1) : b[0];
                     parse_state = brle_pkg::PH_ABS;
                  end
               end
               brle_pkg::PH_ABS: begin
                  if (rle4) begin
                     n = (abs_left >= 2) ? 2 : int'(abs_left);
                     add_run(palette[b[7:4]], palette[b[3:0]], n, 1'b0, 1'b0);
                  end else begin
                     n = 1;
                     add_run(palette[b], palette[b], n, 1'b0, 1'b0);
                  end
                  advance_column(n);
                  abs_left = abs_left - 8'(n);
                  if (abs_left == 0)
                     parse_state = pad_due ? brle_pkg::PH_PAD : brle_pkg::PH_COUNT;
               end
               brle_pkg::PH_PAD: begin
                  pad_due = 1'b0;
                  parse_state = brle_pkg::PH_COUNT;
               end
               brle_pkg::PH_DELTA1: parse_state = brle_pkg::PH_DELTA2;
               brle_pkg::PH_DELTA2: parse_state = brle_pkg::PH_COUNT;
               default: ;
            endcase
         end
      endfunction

      function void compare_field(string name, logic [brle_pkg::LEN_W-1:0] want,
                                  logic [brle_pkg::LEN_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_run(run_rec_type got);
         run_rec_type want;
         if (pending_runs.size() == 0) begin
            $display("%0t: unexpected run even %h odd %h length %0d", $time,
                     got.even_color, got.odd_color, got.run_length);
            errors++;
         end else begin
            want = pending_runs.pop_front();
            runs_checked++;
            if (want.last) bitmaps_done++;
            compare_field("even_color", brle_pkg::LEN_W'(want.even_color),
                          brle_pkg::LEN_W'(got.even_color));
            compare_field("odd_color", brle_pkg::LEN_W'(want.odd_color),
                          brle_pkg::LEN_W'(got.odd_color));
            compare_field("run_length", want.run_length, got.run_length);
            compare_field("row_end", brle_pkg::LEN_W'(want.row_end),
                          brle_pkg::LEN_W'(got.row_end));
            compare_field("last", brle_pkg::LEN_W'(want.last), brle_pkg::LEN_W'(got.last));
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = '0;
   logic [brle_pkg::BYTE_W-1:0] req_stream_byte = '0;
   logic [brle_pkg::BYTE_W-1:0] req_palette_index = '0;
   logic [brle_pkg::COLOR_W-1:0] req_palette_color = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [brle_pkg::COLOR_W-1:0] rsp_even_color;
   logic [brle_pkg::COLOR_W-1:0] rsp_odd_color;
   logic [brle_pkg::LEN_W-1:0] rsp_run_length;
   logic rsp_row_end;
   logic rsp_last;
   logic csr_write = 1'b0;
   logic [brle_pkg::CSR_IW-1:0] csr_index = '0;
   logic [brle_pkg::CSR_W-1:0] csr_data = '0;

   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   run_rec_type seen_run;
   rle_scoreboard_type sb;

   int phase_rle4 [7] = '{1, 0, 1, 0, 1, 0, 1};
   int phase_width [7] = '{16, 4096, 4096, 1, 1, 8191, 37};
   int phase_height [7] = '{8, 4096, 1, 4096, 1, 0, 13};

   bmp_rle_palette_decoder DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_stream_byte(req_stream_byte),
      .req_palette_index(req_palette_index),
      .req_palette_color(req_palette_color),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_even_color(rsp_even_color),
      .rsp_odd_color(rsp_odd_color),
      .rsp_run_length(rsp_run_length),
      .rsp_row_end(rsp_row_end),
      .rsp_last(rsp_last),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : rsp_pacer
      int hold;
      forever begin
         if (!stalls_on || $urandom_range(0, 99) < 55) begin
            rsp_stall <= 1'b0;
            hold = $urandom_range(1, 12);
         end else begin
            rsp_stall <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         end
         repeat (hold) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_run.even_color = rsp_even_color;
         seen_run.odd_color = rsp_odd_color;
         seen_run.run_length = rsp_run_length;
         seen_run.row_end = rsp_row_end;
         seen_run.last = rsp_last;
         sb.check_run(seen_run);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL bmp_rle_palette_decoder");
      $finish;
   end

   task automatic send_request(logic [1:0] m, logic [7:0] b, logic [7:0] idx,
                               logic [brle_pkg::COLOR_W-1:0] rgb);
      int gap;
      int r;
      gap = 0;
      if (gaps_on) begin
         r = $urandom_range(0, 99);
         if (r >= 93) gap = $urandom_range(8, 30);
         else if (r >= 65) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_stream_byte <= b;
      req_palette_index <= idx;
      req_palette_color <= rgb;
      do @(posedge clock); while (req_stall);
      sb.decode_request(m, b, idx, rgb);
   endtask

   task automatic send_byte(logic [7:0] b);
      send_request(brle_pkg::MODE_BYTE, sb.usable_byte(b), 8'($urandom), 24'($urandom));
   endtask

   task automatic send_start();
      send_request(brle_pkg::MODE_START, 8'($urandom), 8'($urandom), 24'($urandom));
   endtask

   task automatic drain_runs();
      req_valid <= 1'b0;
      while (sb.pending_runs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_image(bit use_rle4, int w, int h);
      csr_write <= 1'b1;
      csr_index <= brle_pkg::CSR_COMPRESSION;
      csr_data <= brle_pkg::CSR_W'(use_rle4);
      @(posedge clock);
      sb.set_reg(brle_pkg::CSR_COMPRESSION, int'(use_rle4));
      csr_index <= brle_pkg::CSR_WIDTH;
      csr_data <= brle_pkg::CSR_W'(w);
      @(posedge clock);
      sb.set_reg(brle_pkg::CSR_WIDTH, w);
      csr_index <= brle_pkg::CSR_HEIGHT;
      csr_data <= brle_pkg::CSR_W'(h);
      @(posedge clock);
      sb.set_reg(brle_pkg::CSR_HEIGHT, h);
      csr_write <= 1'b0;
   endtask

   task automatic send_command();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         send_request(brle_pkg::MODE_PALETTE, 8'($urandom),
                      $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom),
                      24'($urandom));
      end else if (r < 42) begin
         n = $urandom_range(0, 99);
         if (n < 70) n = $urandom_range(1, 8);
         else if (n < 95) n = $urandom_range(9, 255);
         else n = 255;
         send_byte(8'(n));
         send_byte(8'($urandom));
      end else if (r < 62) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 10);
         send_byte(ESCAPE_COUNT);
         send_byte(8'(n));
         while (sb.parse_state == brle_pkg::PH_ABS) send_byte(8'($urandom));
         if (sb.parse_state == brle_pkg::PH_PAD) send_byte(8'($urandom));
      end else if (r < 72) begin
         send_byte(ESCAPE_COUNT);
         send_byte(brle_pkg::ESC_EOL);
      end else if (r < 77) begin
         send_byte(ESCAPE_COUNT);
         send_byte(brle_pkg::ESC_DELTA);
         send_byte(8'($urandom));
         send_byte(8'($urandom));
      end else if (r < 80) begin
         send_byte(ESCAPE_COUNT);
         send_byte(brle_pkg::ESC_EOB);
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
         send_start();
      end else if (r < 83) begin
         send_start();
      end else begin
         send_byte(8'($urandom));
      end
   endtask

   initial begin
      int goal;
      bit paused;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      program_image(1'b0, 16, 4);

      send_request(brle_pkg::MODE_PALETTE, 8'h00, 8'd0, 24'h000000);
      send_request(brle_pkg::MODE_PALETTE, 8'hFF, 8'd255, 24'hFFFFFF);
      send_request(brle_pkg::MODE_PALETTE, 8'h5A, 8'd15, 24'($urandom));
      send_request(brle_pkg::MODE_PALETTE, 8'hA5, 8'd1, 24'($urandom));
      send_start();
      // longest encoded run, overruns the row
      send_byte(8'd255);
      send_byte(8'd255);
      // end of line with the column already past the row end
      send_byte(ESCAPE_COUNT);
      send_byte(brle_pkg::ESC_EOL);
      send_byte(8'd1);
      send_byte(8'd0);
      // odd absolute run, then its pad byte
      send_byte(ESCAPE_COUNT);
      send_byte(8'd3);
      send_byte(8'd1);
      send_byte(8'd15);
      send_byte(8'd255);
      send_byte(8'd0);
      send_byte(ESCAPE_COUNT);
      send_byte(brle_pkg::ESC_DELTA);
      send_byte(8'd7);
      send_byte(8'd2);
      send_byte(ESCAPE_COUNT);
      send_byte(brle_pkg::ESC_EOL);
      send_byte(ESCAPE_COUNT);
      send_byte(brle_pkg::ESC_EOB);
      send_byte(8'd9);

      paused = 1'b0;
      for (int p = 0; p < 7; p++) begin
         drain_runs();
         program_image(phase_rle4[p][0], phase_width[p], phase_height[p]);
         gaps_on = (p != 2);
         stalls_on = (p != 2);
         send_start();
         goal = sb.requests + PHASE_REQUESTS;
         while (sb.requests < goal) begin
            send_command();
            // hold the sender until every run so far is out
            if (p == 3 && !paused && sb.requests >= goal - PHASE_REQUESTS / 2) begin
               drain_runs();
               paused = 1'b1;
            end
         end
      end
      drain_runs();

      $display("Sent %0d requests over 8 RLE8/RLE4 settings, widths and heights 1 to 4096",
               sb.requests);
      $display("Checked %0d runs, %0d complete bitmaps, %0d mismatches",
               sb.runs_checked, sb.bitmaps_done, sb.errors);
      if (sb.errors == 0 && sb.pending_runs.size() == 0)
         $display("PASS bmp_rle_palette_decoder");
      else
         $display("FAIL bmp_rle_palette_decoder");
      $finish;
   end

endmodule
